FILE: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros used by the checker file
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define CHK_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

FILE: rtl/tksid_pkg.sv
// ---------------------------------------------------------------------------
// tksid_pkg
// Types and codes of the sorted top-k match list.
// ---------------------------------------------------------------------------
package tksid_pkg;

  localparam int IDX_W  = 5;
  localparam int POS_W  = 5;
  localparam int OCNT_W = 6;
  localparam int LIM_W  = 6;
  localparam int STAT_W = 3;
  localparam int KIND_W = 2;

  localparam logic [KIND_W-1:0] K_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] K_READ   = 2'd1;
  localparam logic [KIND_W-1:0] K_CLEAR  = 2'd2;
  localparam logic [KIND_W-1:0] K_NONE   = 2'd3;

  localparam logic [STAT_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STAT_W-1:0] ST_DUPLICATE = 3'd1;
  localparam logic [STAT_W-1:0] ST_DROPPED   = 3'd2;
  localparam logic [STAT_W-1:0] ST_READ_OK   = 3'd3;
  localparam logic [STAT_W-1:0] ST_READ_BAD  = 3'd4;
  localparam logic [STAT_W-1:0] ST_CLEARED   = 3'd5;

  typedef enum logic [1:0] {
    OP_INSERT,
    OP_READ,
    OP_CLEAR
  } op_t;

  typedef struct packed {
    logic        [31:0] id;
    logic        [31:0] tags;
    logic        [31:0] dkey;
    logic signed [31:0] lat;
    logic signed [31:0] lon;
  } entry_t;

  typedef struct packed {
    op_t              op;
    entry_t           ent;
    logic [IDX_W-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [POS_W-1:0]  position;
    logic [OCNT_W-1:0] entry_count;
    entry_t            ent;
  } res_t;

endpackage

FILE: rtl/tksid_fifo.sv
// ---------------------------------------------------------------------------
// tksid_fifo
// Two-entry command queue between the front end and the list engine.
// ---------------------------------------------------------------------------
module tksid_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_valid,
  output logic              wr_ready,
  input  tksid_pkg::cmd_t   wr_data,
  output logic              rd_valid,
  input  logic              rd_ready,
  output tksid_pkg::cmd_t   rd_data
);

  tksid_pkg::cmd_t q_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = q_r[rp_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= wr_data;
    end
  end

endmodule

FILE: rtl/tksid_front.sv
// ---------------------------------------------------------------------------
// tksid_front
// Input stage: accept items, decode the kind, drop unused kinds.
// ---------------------------------------------------------------------------
module tksid_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [tksid_pkg::KIND_W-1:0]  in_kind,
  input  tksid_pkg::entry_t             in_ent,
  input  logic [tksid_pkg::IDX_W-1:0]   in_idx,
  output logic                          cmd_valid,
  input  logic                          cmd_ready,
  output tksid_pkg::cmd_t               cmd
);

  logic            fr_valid_r;
  tksid_pkg::cmd_t cmd_r, cmd_nxt;
  logic            keep;

  assign in_ready  = !fr_valid_r || cmd_ready;
  assign cmd_valid = fr_valid_r;
  assign cmd       = cmd_r;

  // Classify the item; the unused kind produces no command.
  always_comb begin
    cmd_nxt.ent = in_ent;
    cmd_nxt.idx = in_idx;
    keep        = 1'b1;
    case (in_kind)
      tksid_pkg::K_INSERT: cmd_nxt.op = tksid_pkg::OP_INSERT;
      tksid_pkg::K_READ:   cmd_nxt.op = tksid_pkg::OP_READ;
      tksid_pkg::K_CLEAR:  cmd_nxt.op = tksid_pkg::OP_CLEAR;
      default: begin
        cmd_nxt.op = tksid_pkg::OP_CLEAR;
        keep       = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      fr_valid_r <= keep;
    end else if (cmd_ready) begin
      fr_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r <= cmd_nxt;
    end
  end

endmodule

FILE: rtl/tksid_list.sv
// ---------------------------------------------------------------------------
// tksid_list
// List engine: compare against every cell, then insert, read or clear.
// ---------------------------------------------------------------------------
module tksid_list #(
  parameter  int CAPACITY = 32,
  localparam int CW       = $clog2(CAPACITY + 1)
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [CW-1:0]   lim,
  input  logic            cmd_valid,
  output logic            cmd_ready,
  input  tksid_pkg::cmd_t cmd,
  output logic            out_valid,
  input  logic            out_ready,
  output tksid_pkg::res_t res
);

  typedef enum logic {S_IDLE, S_APPLY} state_t;

  state_t               state_r;
  tksid_pkg::entry_t    cell_r [CAPACITY];
  tksid_pkg::entry_t    cell_nxt [CAPACITY];
  logic [CW-1:0]        cnt_r, cnt_nxt;
  tksid_pkg::cmd_t      cmd_r;
  logic [CAPACITY-1:0]  eq_r, eq_c;
  logic [CAPACITY-1:0]  gt_r, gt_c;
  tksid_pkg::entry_t    rd_r, rd_c;
  logic                 rd_ok_r, rd_ok_c;
  logic                 out_valid_r;
  tksid_pkg::res_t      res_r, res_nxt;

  logic                 dup_any;
  logic [CW-1:0]        dup_pos;
  logic [CAPACITY-1:0]  first_gt;
  logic [CW-1:0]        ins_pos;
  logic                 drop;
  logic [CW-1:0]        last;
  logic                 do_ins;
  logic                 apply_fire;

  assign cmd_ready  = (state_r == S_IDLE);
  assign out_valid  = out_valid_r;
  assign res        = res_r;
  assign apply_fire = (state_r == S_APPLY) && (!out_valid_r || out_ready);

  // Compare the incoming command against every held cell.
  always_comb begin
    rd_c    = '0;
    rd_ok_c = (9'(cmd.idx) < 9'(cnt_r));
    for (int i = 0; i < CAPACITY; i++) begin
      eq_c[i] = (CW'(i) < cnt_r) && (cell_r[i].id == cmd.ent.id);
      gt_c[i] = (CW'(i) < cnt_r) && (cmd.ent.dkey < cell_r[i].dkey);
      if (9'(i) == 9'(cmd.idx)) begin
        rd_c = cell_r[i];
      end
    end
  end

  // Resolve positions. Held ids are unique, so an OR of indices gives the hit;
  // the greater-than vector is a suffix of the valid cells.
  always_comb begin
    dup_any  = |eq_r;
    dup_pos  = '0;
    first_gt = gt_r & ~{gt_r[CAPACITY-2:0], 1'b0};
    ins_pos  = (|first_gt) ? '0 : cnt_r;
    for (int i = 0; i < CAPACITY; i++) begin
      if (eq_r[i]) begin
        dup_pos = dup_pos | CW'(i);
      end
      if (first_gt[i]) begin
        ins_pos = ins_pos | CW'(i);
      end
    end
    drop   = (ins_pos >= lim);
    last   = (cnt_r >= lim) ? (lim - CW'(1)) : cnt_r;
    do_ins = (cmd_r.op == tksid_pkg::OP_INSERT) && !dup_any && !drop;
  end

  // Shift the tail down and place the new entry.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      cell_nxt[i] = cell_r[i];
    end
    if (do_ins) begin
      if (ins_pos == '0) begin
        cell_nxt[0] = cmd_r.ent;
      end
      for (int i = 1; i < CAPACITY; i++) begin
        if (CW'(i) == ins_pos) begin
          cell_nxt[i] = cmd_r.ent;
        end else if ((CW'(i) > ins_pos) && (CW'(i) <= last)) begin
          cell_nxt[i] = cell_r[i-1];
        end
      end
    end
  end

  always_comb begin
    cnt_nxt             = cnt_r;
    res_nxt.ent         = '0;
    res_nxt.position    = '0;
    res_nxt.status      = tksid_pkg::ST_CLEARED;
    case (cmd_r.op)
      tksid_pkg::OP_INSERT: begin
        if (dup_any) begin
          res_nxt.status   = tksid_pkg::ST_DUPLICATE;
          res_nxt.position = tksid_pkg::POS_W'(dup_pos);
        end else if (drop) begin
          res_nxt.status   = tksid_pkg::ST_DROPPED;
        end else begin
          res_nxt.status   = tksid_pkg::ST_INSERTED;
          res_nxt.position = tksid_pkg::POS_W'(ins_pos);
          if (cnt_r < lim) begin
            cnt_nxt = cnt_r + CW'(1);
          end
        end
      end
      tksid_pkg::OP_READ: begin
        res_nxt.position = cmd_r.idx;
        if (rd_ok_r) begin
          res_nxt.status = tksid_pkg::ST_READ_OK;
          res_nxt.ent    = rd_r;
        end else begin
          res_nxt.status = tksid_pkg::ST_READ_BAD;
        end
      end
      tksid_pkg::OP_CLEAR: begin
        cnt_nxt = '0;
      end
      default: begin
        cnt_nxt = cnt_r;
      end
    endcase
    res_nxt.entry_count = tksid_pkg::OCNT_W'(cnt_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      res_r       <= '0;
    end else begin
      case (state_r)
        S_IDLE: begin
          // Drop the result once taken.
          if (out_valid_r && out_ready) begin
            out_valid_r <= 1'b0;
          end
          if (cmd_valid) begin
            state_r <= S_APPLY;
          end
        end
        S_APPLY: begin
          if (apply_fire) begin
            out_valid_r <= 1'b1;
            res_r       <= res_nxt;
            cnt_r       <= cnt_nxt;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Payload: compare results and the cells themselves.
  always_ff @(posedge clk) begin
    if (cmd_valid && cmd_ready) begin
      cmd_r   <= cmd;
      eq_r    <= eq_c;
      gt_r    <= gt_c;
      rd_r    <= rd_c;
      rd_ok_r <= rd_ok_c;
    end
    if (apply_fire) begin
      for (int i = 0; i < CAPACITY; i++) begin
        cell_r[i] <= cell_nxt[i];
      end
    end
  end

endmodule

FILE: rtl/top_k_sorted_insert_dedup.sv
// ---------------------------------------------------------------------------
// top_k_sorted_insert_dedup
// Bounded list of matches kept sorted by ascending distance, with duplicate
// rejection by id, reads by index and clear.
// ---------------------------------------------------------------------------
// An accepted item passes the front register, the queue and the list engine's
//   compare and write-back states before out_tvalid rises. The list engine
//   takes no new item before writing back the last one; the front stage and a
//   two-entry queue keep taking items while a result waits.
// Reset: held count and result limit go to zero; entry storage is not cleared
//   and needs no clearing pass, since only written entries are ever read.
// ---------------------------------------------------------------------------
module top_k_sorted_insert_dedup #(
  parameter int CAPACITY = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  // in_tdata, from bit 0: entry_id[31:0], entry_tags[63:32],
  //   distance_key[95:64], latitude[127:96], longitude[159:128],
  //   read_index[164:160], zero fill [167:165]
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [167:0] in_tdata,
  // in_tuser, from bit 0: kind[1:0]
  input  logic [1:0]   in_tuser,
  // out_tdata, from bit 0: position[4:0], entry_count[10:5], out_id[42:11],
  //   out_mask[74:43], out_distance[106:75], out_latitude[138:107],
  //   out_longitude[170:139], zero fill [175:171]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [175:0] out_tdata,
  // out_tuser, from bit 0: status[2:0]
  output logic [2:0]   out_tuser,
  // result_limit write port
  input  logic         cfg_we,
  input  logic [5:0]   cfg_wdata
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int WW = (CW > tksid_pkg::LIM_W) ? CW : tksid_pkg::LIM_W;

  logic [tksid_pkg::LIM_W-1:0] limit_r;
  logic [CW-1:0]               eff_lim;
  tksid_pkg::entry_t           in_ent;
  logic                        fr_valid, fr_ready;
  tksid_pkg::cmd_t             fr_cmd;
  logic                        q_valid, q_ready;
  tksid_pkg::cmd_t             q_cmd;
  tksid_pkg::res_t             res;

  // Hold limit_r. Users must change configuration only while idle; unchecked.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= '0;
    end else if (cfg_we) begin
      limit_r <= cfg_wdata;
    end
  end

  // Zero, or anything above capacity, selects full capacity.
  always_comb begin
    if ((WW'(limit_r) == '0) || (WW'(limit_r) > WW'(CAPACITY))) begin
      eff_lim = CW'(CAPACITY);
    end else begin
      eff_lim = CW'(limit_r);
    end
  end

  // Unpack the input item.
  assign in_ent.id   = in_tdata[31:0];
  assign in_ent.tags = in_tdata[63:32];
  assign in_ent.dkey = in_tdata[95:64];
  assign in_ent.lat  = in_tdata[127:96];
  assign in_ent.lon  = in_tdata[159:128];

  tksid_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_kind   (in_tuser),
    .in_ent    (in_ent),
    .in_idx    (in_tdata[164:160]),
    .cmd_valid (fr_valid),
    .cmd_ready (fr_ready),
    .cmd       (fr_cmd)
  );

  tksid_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fr_valid),
    .wr_ready (fr_ready),
    .wr_data  (fr_cmd),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_cmd)
  );

  tksid_list #(
    .CAPACITY (CAPACITY)
  ) u_list (
    .clk       (clk),
    .rst_n     (rst_n),
    .lim       (eff_lim),
    .cmd_valid (q_valid),
    .cmd_ready (q_ready),
    .cmd       (q_cmd),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .res       (res)
  );

  // Pack the result item.
  assign out_tuser = res.status;
  assign out_tdata = {5'd0, res.ent.lon, res.ent.lat, res.ent.dkey, res.ent.tags,
                      res.ent.id, res.entry_count, res.position};

endmodule

FILE: rtl/tksid_checker.sv
// ---------------------------------------------------------------------------
// tksid_checker
// Port-level checks on the result stream of the sorted match list.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module tksid_checker #(
  parameter int CAPACITY = 32
) (
  input logic         clk,
  input logic         rst_n,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [175:0] out_tdata,
  input logic [2:0]   out_tuser
);

  logic is_read_ok;
  logic is_cleared;

  assign is_read_ok = out_tvalid && (out_tuser == tksid_pkg::ST_READ_OK);
  assign is_cleared = out_tvalid && (out_tuser == tksid_pkg::ST_CLEARED);

  // A stalled result holds.
  `CHK_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready,
            out_tvalid && $stable(out_tdata) && $stable(out_tuser))

  // Only a good read carries entry fields.
  `CHK_IMPL(a_payload_zero, clk, rst_n, out_tvalid && !is_read_ok,
            out_tdata[170:11] == '0)

  // A clear reports position zero and an empty list.
  `CHK_IMPL(a_clear_empty, clk, rst_n, is_cleared, out_tdata[10:0] == '0)

  // A good read points inside the held entries.
  `CHK_IMPL(a_read_in_range, clk, rst_n, is_read_ok,
            (CAPACITY >= 64) || ({1'b0, out_tdata[4:0]} < out_tdata[10:5]))

endmodule

bind top_k_sorted_insert_dedup tksid_checker #(
  .CAPACITY (CAPACITY)
) u_tksid_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

FILE: sim/top_k_sorted_insert_dedup_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// top_k_sorted_insert_dedup_test
// Self-checking bench for the sorted top-k match list. A directed table covers
// empty reads, field extremes, duplicates, ties, drops, clears and a limit
// lowered under the held count; random phases follow under several limits.
// Every result is compared field by field with its typed row or a local list copy.
// ----------------------------------------------------------------------------
module top_k_sorted_insert_dedup_test;

  localparam int CAP         = 32;
  localparam int PHASE_ITEMS = 200;
  localparam int NUM_PHASES  = 8;
  localparam int LONG_HOLD   = 300;   // receiver hold-off that backs up the block
  localparam int DRAIN_WAIT  = 10;    // lets result-less items leave the pipeline
  localparam int WATCHDOG    = 2000;  // cycles with no transfer at all

  // One row of the directed table: either a limit write or an item.
  typedef struct {
    bit                          is_cfg;
    logic [tksid_pkg::LIM_W-1:0] cfg_val;
    logic [1:0]                  kind;
    tksid_pkg::entry_t           ent;
    logic [tksid_pkg::IDX_W-1:0] idx;
    bit                          typed;   // expected result written in the row
    tksid_pkg::res_t             want;
  } dir_row_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  // in_tdata, from bit 0: entry_id, entry_tags, distance_key, latitude,
  //   longitude, read_index, zero fill
  logic [167:0] in_tdata;
  // in_tuser, from bit 0: kind
  logic [1:0]   in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  // out_tdata, from bit 0: position, entry_count, out_id, out_mask,
  //   out_distance, out_latitude, out_longitude, zero fill
  logic [175:0] out_tdata;
  // out_tuser, from bit 0: status
  logic [2:0]   out_tuser;
  logic         cfg_we;
  logic [5:0]   cfg_wdata;

  // Local copy of the list, its count and the limit register.
  tksid_pkg::entry_t           list_mem [CAP];
  int                          list_count;
  logic [tksid_pkg::LIM_W-1:0] list_limit;

  tksid_pkg::res_t pending_q [$];   // expected results, oldest first
  dir_row_t        dir_rows  [$];

  int err_count;
  int items_accepted;
  int results_checked;
  int limit_writes;
  int stat_seen [6];
  int idle_cycles;
  int hold_left;
  bit hold_req;
  bit hold_done;
  bit tx_steady;
  bit rx_steady;

  top_k_sorted_insert_dedup #(
    .CAPACITY(CAP)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Apply one item to the local list and build the result it causes.
  // Return 0 for the unused kind, which leaves no result.
  function automatic bit predict_item(input logic [1:0] kind, input tksid_pkg::entry_t e,
                                      input logic [tksid_pkg::IDX_W-1:0] idx,
                                      output tksid_pkg::res_t r);
    int i;
    int n;
    int lim;
    int pos;
    int last;
    int dup_at;
    r      = '0;
    n      = list_count;
    lim    = (list_limit == 0 || list_limit > CAP) ? CAP : int'(list_limit);
    dup_at = -1;
    case (kind)
      tksid_pkg::K_INSERT: begin
        for (i = 0; i < n; i++)
          if (dup_at < 0 && list_mem[i].id == e.id) dup_at = i;
        if (dup_at >= 0) begin
          r.status   = tksid_pkg::ST_DUPLICATE;
          r.position = dup_at[tksid_pkg::POS_W-1:0];
        end else begin
          // Find the first held entry with a strictly greater distance.
          pos = n;
          for (i = n - 1; i >= 0; i--)
            if (e.dkey < list_mem[i].dkey) pos = i;
          if (pos >= lim) begin
            r.status = tksid_pkg::ST_DROPPED;
          end else begin
            // Shift down; at the limit the entry at lim-1 falls off.
            last = (n >= lim) ? lim - 1 : n;
            for (i = last; i > pos; i--) list_mem[i] = list_mem[i-1];
            list_mem[pos] = e;
            if (n < lim) list_count = n + 1;
            r.status   = tksid_pkg::ST_INSERTED;
            r.position = pos[tksid_pkg::POS_W-1:0];
          end
        end
      end
      tksid_pkg::K_READ: begin
        r.position = idx;
        if (idx < n) begin
          r.status = tksid_pkg::ST_READ_OK;
          r.ent    = list_mem[idx];
        end else begin
          r.status = tksid_pkg::ST_READ_BAD;
        end
      end
      tksid_pkg::K_CLEAR: begin
        list_count = 0;
        r.status   = tksid_pkg::ST_CLEARED;
      end
      default: return 1'b0;
    endcase
    r.entry_count = list_count[tksid_pkg::OCNT_W-1:0];
    return 1'b1;
  endfunction

  function automatic tksid_pkg::res_t mk_res(input logic [tksid_pkg::STAT_W-1:0] st,
                                             input int pos, input int cnt);
    tksid_pkg::res_t r;
    r             = '0;
    r.status      = st;
    r.position    = pos[tksid_pkg::POS_W-1:0];
    r.entry_count = cnt[tksid_pkg::OCNT_W-1:0];
    return r;
  endfunction

  function automatic tksid_pkg::entry_t mk_ent(input logic [31:0] id, input logic [31:0] tags,
                                               input logic [31:0] dkey, input logic [31:0] lat,
                                               input logic [31:0] lon);
    tksid_pkg::entry_t e;
    e.id   = id;
    e.tags = tags;
    e.dkey = dkey;
    e.lat  = lat;
    e.lon  = lon;
    return e;
  endfunction

  task automatic add_item(input logic [1:0] kind, input tksid_pkg::entry_t e, input int idx,
                          input bit typed, input tksid_pkg::res_t want);
    dir_row_t row;
    row.is_cfg  = 1'b0;
    row.cfg_val = '0;
    row.kind    = kind;
    row.ent     = e;
    row.idx     = idx[tksid_pkg::IDX_W-1:0];
    row.typed   = typed;
    row.want    = want;
    dir_rows.push_back(row);
  endtask

  task automatic add_cfg(input logic [tksid_pkg::LIM_W-1:0] val);
    dir_row_t row;
    row         = '{default: '0};
    row.is_cfg  = 1'b1;
    row.cfg_val = val;
    dir_rows.push_back(row);
  endtask

  // Offer one item after a random gap, hold it until accepted, then record
  // what it should produce. Leave tvalid high; the next call or the caller
  // decides whether it drops.
  task automatic send_item(input logic [1:0] kind, input tksid_pkg::entry_t e,
                           input logic [tksid_pkg::IDX_W-1:0] idx, input bit typed,
                           input tksid_pkg::res_t want);
    int              gap;
    int              roll;
    tksid_pkg::res_t pred;
    bit              has;
    gap = 0;
    if (!tx_steady) begin
      roll = $urandom_range(0, 99);
      if (roll >= 92) gap = $urandom_range(8, 40);
      else if (roll >= 60) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {3'b000, idx, e.lon, e.lat, e.dkey, e.tags, e.id};
    do @(posedge clk); while (!in_tready);
    items_accepted++;
    has = predict_item(kind, e, idx, pred);
    if (has) pending_q.push_back(typed ? want : pred);
  endtask

  // Change the limit only with the block idle: drop tvalid, drain every
  // pending result, let any result-less item clear the pipeline, then write.
  task automatic write_limit(input logic [tksid_pkg::LIM_W-1:0] val);
    in_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    cfg_we     <= 1'b1;
    cfg_wdata  <= val;
    @(posedge clk);
    cfg_we     <= 1'b0;
    list_limit  = val;
    limit_writes++;
  endtask

  task automatic compare_field(input string fld, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, fld, want, got);
      err_count++;
    end
  endtask

  task automatic check_result();
    tksid_pkg::res_t got;
    tksid_pkg::res_t want;
    got.status      = out_tuser;
    got.position    = out_tdata[4:0];
    got.entry_count = out_tdata[10:5];
    got.ent.id      = out_tdata[42:11];
    got.ent.tags    = out_tdata[74:43];
    got.ent.dkey    = out_tdata[106:75];
    got.ent.lat     = out_tdata[138:107];
    got.ent.lon     = out_tdata[170:139];
    if (pending_q.size() == 0) begin
      $display("%0t: result with nothing pending, expected none, got status %0d",
               $time, got.status);
      err_count++;
    end else begin
      want = pending_q.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("position", want.position, got.position);
      compare_field("entry_count", want.entry_count, got.entry_count);
      compare_field("out_id", want.ent.id, got.ent.id);
      compare_field("out_mask", want.ent.tags, got.ent.tags);
      compare_field("out_distance", want.ent.dkey, got.ent.dkey);
      compare_field("out_latitude", want.ent.lat, got.ent.lat);
      compare_field("out_longitude", want.ent.lon, got.ent.lon);
    end
    if (got.status <= tksid_pkg::ST_CLEARED) stat_seen[got.status]++;
    results_checked++;
  endtask

  // Receiver: check each result taken, then pick tready for the next cycle.
  // Short random stalls, a few longer ones, once a long hold-off; none if steady.
  always @(posedge clk) begin : rx_side
    int roll;
    if (rst_n) begin
      if (out_tvalid && out_tready) check_result();
      if (hold_left > 0) begin
        hold_left  <= hold_left - 1;
        out_tready <= 1'b0;
      end else if (hold_req && !hold_done) begin
        hold_left  <= LONG_HOLD;
        hold_done  <= 1'b1;
        out_tready <= 1'b0;
      end else if (rx_steady) begin
        out_tready <= 1'b1;
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
          hold_left  <= $urandom_range(8, 40);
          out_tready <= 1'b0;
        end else begin
          out_tready <= (roll < 75);
        end
      end
    end
  end

  // Watchdog: end the run if nothing moves for too long.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("%0t: no transfer for %0d cycles", $time, WATCHDOG);
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int                          k;
    int                          p;
    int                          roll;
    logic [1:0]                  kind;
    tksid_pkg::entry_t           e;
    logic [tksid_pkg::IDX_W-1:0] idx;
    logic [tksid_pkg::LIM_W-1:0] phase_limit [NUM_PHASES];

    // Drive every input to a known value before the first edge.
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= tksid_pkg::K_INSERT;
    out_tready <= 1'b0;
    cfg_we     <= 1'b0;
    cfg_wdata  <= '0;
    hold_req   <= 1'b0;
    hold_done   = 1'b0;
    hold_left   = 0;
    idle_cycles = 0;
    tx_steady   = 1'b0;
    rx_steady   = 1'b0;
    list_count  = 0;
    list_limit  = '0;
    foreach (stat_seen[k]) stat_seen[k] = 0;

    // Directed table. Typed rows carry their result; the rest go to the predictor.
    // Empty list: reads at both ends of the index range are out of range.
    add_item(tksid_pkg::K_READ, mk_ent(0, 0, 0, 0, 0), 0, 1,
             mk_res(tksid_pkg::ST_READ_BAD, 0, 0));
    add_item(tksid_pkg::K_READ, mk_ent(0, 0, 0, 0, 0), 31, 1,
             mk_res(tksid_pkg::ST_READ_BAD, 31, 0));
    // Unused kind: no result, nothing changes.
    add_item(tksid_pkg::K_NONE, mk_ent('1, '1, '1, '1, '1), 31, 0, '0);
    // Field extremes: lowest id, most negative latitude, most positive longitude.
    add_item(tksid_pkg::K_INSERT, mk_ent(0, 0, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff),
             0, 1, mk_res(tksid_pkg::ST_INSERTED, 0, 1));
    // Same id again is a duplicate, whatever the distance.
    add_item(tksid_pkg::K_INSERT, mk_ent(0, '1, 0, 0, 0), 0, 1,
             mk_res(tksid_pkg::ST_DUPLICATE, 0, 1));
    // Largest distance lands at the end.
    add_item(tksid_pkg::K_INSERT, mk_ent('1, '1, '1, 32'h7fff_ffff, 32'h8000_0000), 31,
             1, mk_res(tksid_pkg::ST_INSERTED, 1, 2));
    // Equal distances keep arrival order.
    add_item(tksid_pkg::K_INSERT, mk_ent(5, 32'ha5a5_a5a5, 0, 32'h1234_5678, 32'hfedc_ba98),
             0, 0, '0);
    add_item(tksid_pkg::K_INSERT, mk_ent(6, 32'h5a5a_5a5a, 0, 32'hffff_ffff, 32'h0000_0001),
             0, 0, '0);
    add_item(tksid_pkg::K_INSERT, mk_ent(7, 32'h0f0f_0f0f, 32'h8000_0000, 1, 2), 0, 0, '0);
    for (k = 0; k < 3; k++) add_item(tksid_pkg::K_READ, mk_ent(0, 0, 0, 0, 0), k, 0, '0);
    add_item(tksid_pkg::K_READ, mk_ent(0, 0, 0, 0, 0), 5, 1,
             mk_res(tksid_pkg::ST_READ_BAD, 5, 5));
    add_item(tksid_pkg::K_CLEAR, mk_ent(0, 0, 0, 0, 0), 0, 1,
             mk_res(tksid_pkg::ST_CLEARED, 0, 0));
    add_item(tksid_pkg::K_READ, mk_ent(0, 0, 0, 0, 0), 0, 1,
             mk_res(tksid_pkg::ST_READ_BAD, 0, 0));
    // Limit of one: a later distance is dropped, a smaller one replaces.
    add_cfg(1);
    add_item(tksid_pkg::K_INSERT, mk_ent(10, 1, 100, 3, 4), 0, 1,
             mk_res(tksid_pkg::ST_INSERTED, 0, 1));
    add_item(tksid_pkg::K_INSERT, mk_ent(11, 2, 200, 5, 6), 0, 1,
             mk_res(tksid_pkg::ST_DROPPED, 0, 1));
    add_item(tksid_pkg::K_INSERT, mk_ent(12, 3, 50, 7, 8), 0, 1,
             mk_res(tksid_pkg::ST_INSERTED, 0, 1));
    add_item(tksid_pkg::K_READ, mk_ent(0, 0, 0, 0, 0), 0, 0, '0);
    // Fill to four, then lower the limit under the held count.
    add_cfg(0);
    add_item(tksid_pkg::K_INSERT, mk_ent(13, 4, 60, 9, 10), 0, 0, '0);
    add_item(tksid_pkg::K_INSERT, mk_ent(14, 5, 70, 11, 12), 0, 0, '0);
    add_item(tksid_pkg::K_INSERT, mk_ent(15, 6, 80, 13, 14), 0, 0, '0);
    add_cfg(2);
    add_item(tksid_pkg::K_INSERT, mk_ent(16, 7, 40, 15, 16), 0, 0, '0);
    add_item(tksid_pkg::K_INSERT, mk_ent(17, 8, 55, 17, 18), 0, 0, '0);
    add_item(tksid_pkg::K_READ, mk_ent(0, 0, 0, 0, 0), 3, 0, '0);

    // Limits of the random phases: zero, capacity, the top of the field,
    // one, just above capacity and a few in between.
    phase_limit[0] = 6'd0;
    phase_limit[1] = 6'd32;
    phase_limit[2] = 6'd2;
    phase_limit[3] = 6'd63;
    phase_limit[4] = 6'd1;
    phase_limit[5] = 6'd33;
    phase_limit[6] = tksid_pkg::LIM_W'($urandom_range(3, 31));
    phase_limit[7] = 6'd17;

    // Hold reset once, then release it.
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed table.
    foreach (dir_rows[k]) begin
      if (dir_rows[k].is_cfg)
        write_limit(dir_rows[k].cfg_val);
      else
        send_item(dir_rows[k].kind, dir_rows[k].ent, dir_rows[k].idx,
                  dir_rows[k].typed, dir_rows[k].want);
    end

    // Random phases. The list is not cleared between phases, so a smaller
    // limit often meets a fuller list.
    for (p = 0; p < NUM_PHASES; p++) begin
      write_limit(phase_limit[p]);
      tx_steady = (p == 3);
      rx_steady = (p == 3);
      // Back up the block once: the receiver holds off while items keep coming.
      if (p == 1) hold_req <= 1'b1;
      for (k = 0; k < PHASE_ITEMS; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < 62 || roll >= 98) kind = tksid_pkg::K_INSERT;
        else if (roll < 93)          kind = tksid_pkg::K_READ;
        else if (roll < 95)          kind = tksid_pkg::K_CLEAR;
        else                         kind = tksid_pkg::K_NONE;
        // A small id pool makes duplicates common; full draws reach every bit.
        e.id = ($urandom_range(0, 9) < 8) ? 32'($urandom_range(0, 47)) : $urandom();
        roll = $urandom_range(0, 9);
        if (roll < 5)      e.dkey = 32'($urandom_range(0, 31)) << 12;  // many ties
        else if (roll < 8) e.dkey = 32'($urandom_range(0, 1000));
        else               e.dkey = $urandom();
        e.tags = $urandom();
        e.lat  = $urandom();
        e.lon  = $urandom();
        if (list_count > 0 && $urandom_range(0, 1) == 1)
          idx = tksid_pkg::IDX_W'($urandom_range(0, list_count - 1));
        else
          idx = tksid_pkg::IDX_W'($urandom_range(0, 31));
        send_item(kind, e, idx, 1'b0, '0);
      end
    end

    // Drop tvalid, drain, and give stray results time to show up.
    in_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Run covered %0d items, %0d results, %0d limit writes", items_accepted,
             results_checked, limit_writes);
    $display("Inserted %0d, duplicate %0d, dropped %0d, read ok %0d, out of range %0d",
             stat_seen[tksid_pkg::ST_INSERTED], stat_seen[tksid_pkg::ST_DUPLICATE],
             stat_seen[tksid_pkg::ST_DROPPED], stat_seen[tksid_pkg::ST_READ_OK],
             stat_seen[tksid_pkg::ST_READ_BAD]);
    $display("Cleared %0d", stat_seen[tksid_pkg::ST_CLEARED]);
    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", err_count);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/tksid_pkg.sv
rtl/tksid_fifo.sv
rtl/tksid_front.sv
rtl/tksid_list.sv
rtl/top_k_sorted_insert_dedup.sv
rtl/tksid_checker.sv
sim/top_k_sorted_insert_dedup_test.sv
